// File: hw/rtl/stream_find_and_replace_defines.svh
// ----------------------------------------------------------------------------
// Stream find-and-replace assertion macros
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_AND_REPLACE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every edge outside reset
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition now implies expression at the next edge
`define SFR_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define SFR_ASSERT(label, prop, msg)
`define SFR_ASSERT_NEXT(label, cond, expr, msg)
`endif

`endif

// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and register codes of the stream find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  // default capacities
  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;

  // job queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: hw/rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels of the stream find-and-replace block: input bytes,
// result bytes and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

// input byte stream
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       string_end;

  modport source (output valid, data_byte, byte_present, string_end, input ready);
  modport sink   (input valid, data_byte, byte_present, string_end, output ready);
endinterface

// result byte stream
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_present;
  logic       out_string_end;
  logic       run_last;

  modport source (output valid, out_byte, out_present, out_string_end, run_last,
                  input ready);
  modport sink   (input valid, out_byte, out_present, out_string_end, run_last,
                  output ready);
endinterface

// register write channel
interface sfr_cfg_if import sfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Byte-stream find-and-replace with a registered result stream.
// ----------------------------------------------------------------------------
// Takes one input request per cycle as long as each request makes at most one
// result byte and the result side keeps up; requests that only fill the match
// window make no result and never slow the input. A request that makes k
// results (a replacement burst or an end of string flush, k up to the larger
// of MAX_PATTERN and MAX_REPLACEMENT) holds the output while the back end
// plays out one byte per cycle as the result side takes them. The burst job
// stays at the head of the two-entry job queue until its last byte goes out,
// so the front can take one more result-making request behind it; ready then
// drops until that last byte moves into the output stage. A result passes
// through the job queue and the registered output stage before it is
// presented. Register writes are taken every cycle; a write of pattern_length
// drops the bytes held in the window.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace import sfr_pkg::*; #(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sfr_in_if.sink     in_stream,
  sfr_out_if.source  out_stream,
  sfr_cfg_if.sink    cfg
);

  localparam int JOB_MAX = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CNT_W   = $clog2(JOB_MAX + 1);
  localparam int JOB_W   = JOB_MAX * 8 + CNT_W + 2;

  logic             push;
  logic [JOB_W-1:0] job_data;
  logic             queue_full;
  logic             pop;
  logic             head_valid;
  logic [JOB_W-1:0] head_data;

  // window, matching and job build
  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .cfg        (cfg),
    .push       (push),
    .job_data   (job_data),
    .queue_full (queue_full)
  );

  // job queue
  sfr_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (job_data),
    .full   (queue_full),
    .pop    (pop),
    .rvalid (head_valid),
    .rdata  (head_data)
  );

  // result serializer
  sfr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// Short register FIFO of emit jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue import sfr_pkg::*; #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output logic [WIDTH-1:0] rdata
);

  logic [DEPTH-1:0][WIDTH-1:0] slots;
  logic [PTR_W-1:0]            wptr;
  logic [PTR_W-1:0]            rptr;
  logic [CNT_W-1:0]            used;

  assign full   = (used == CNT_W'(DEPTH));
  assign rvalid = (used != '0);
  assign rdata  = slots[rptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        used <= used + CNT_W'(1);
      end else if (pop && !push) begin
        used <= used - CNT_W'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Accepts input bytes and register writes, keeps the match window and turns
// each request that makes results or ends a string into one emit job: a byte list, its length and end mark.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_find_and_replace_defines.svh"

module sfr_front import sfr_pkg::*; #(
  parameter  int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter  int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF,
  localparam int JOB_MAX = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
  localparam int CNT_W   = $clog2(JOB_MAX + 1),
  localparam int JOB_W   = JOB_MAX * 8 + CNT_W + 2
) (
  input  logic             clk,
  input  logic             rst,
  sfr_in_if.sink           in_stream,
  sfr_cfg_if.sink          cfg,
  output logic             push,
  output logic [JOB_W-1:0] job_data,
  input  logic             queue_full
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  typedef struct packed {
    logic [JOB_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic                    present;
    logic                    str_end;
  } job_t;

  // configuration registers
  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]      replacement_length;

  // match window
  logic [MAX_PATTERN-1:0][7:0] window;
  logic [FILL_W-1:0]           fill;

  logic [MAX_PATTERN-1:0][7:0] win_new;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [FILL_W-1:0]           fill_next;
  logic [FILL_W-1:0]           plen;
  logic [CNT_W-1:0]            rlen;
  logic [FILL_W-1:0]           fill_base;
  logic [FILL_W-1:0]           n_win;
  logic                        match;
  logic                        use_repl;
  logic [CNT_W-1:0]            count;
  logic [JOB_MAX-1:0][7:0]     bytes_win;
  logic [JOB_MAX-1:0][7:0]     bytes_rep;
  logic                        take;
  job_t                        job;

  assign cfg.ready       = 1'b1;
  assign in_stream.ready = !queue_full;
  assign take            = in_stream.valid && in_stream.ready;

  // saturated lengths
  always_comb begin
    plen = (pattern_length > LEN_W'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN)
                                                  : FILL_W'(pattern_length);
    rlen = (replacement_length > LEN_W'(MAX_REPLACEMENT)) ? CNT_W'(MAX_REPLACEMENT)
                                                          : CNT_W'(replacement_length);
  end

  // window with the new byte placed, and the full-window compare
  always_comb begin
    fill_base = (fill >= plen) ? '0 : fill;
    n_win     = in_stream.byte_present ? fill_base + FILL_W'(1) : fill_base;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_new[i] = (in_stream.byte_present && fill_base == FILL_W'(i))
                   ? in_stream.data_byte : window[i];
    end
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FILL_W'(i) < plen && win_new[i] != pattern_bytes[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  // candidate byte lists
  always_comb begin
    bytes_win = '0;
    bytes_rep = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      bytes_win[i] = win_new[i];
    end
    for (int i = 0; i < MAX_REPLACEMENT; i++) begin
      bytes_rep[i] = replacement_bytes[8*i +: 8];
    end
  end

  // classify the request
  always_comb begin
    use_repl    = 1'b0;
    count       = '0;
    fill_next   = n_win;
    window_next = win_new;
    if (in_stream.byte_present && plen == '0) begin
      // pass through
      count     = CNT_W'(1);
      fill_next = '0;
    end else if (in_stream.byte_present && n_win == plen) begin
      if (match) begin
        use_repl  = 1'b1;
        count     = rlen;
        fill_next = '0;
      end else if (in_stream.string_end) begin
        // oldest byte and the rest of the window go out together
        count     = CNT_W'(plen);
        fill_next = '0;
      end else begin
        count = CNT_W'(1);
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          window_next[i] = win_new[i + 1];
        end
        fill_next = plen - FILL_W'(1);
      end
    end else if (in_stream.string_end) begin
      count     = CNT_W'(n_win);
      fill_next = '0;
    end

    // job record; an end with nothing to emit becomes a bare end mark
    job.str_end = in_stream.string_end;
    if (count == '0) begin
      job.bytes   = '0;
      job.count   = CNT_W'(1);
      job.present = 1'b0;
    end else begin
      job.bytes   = use_repl ? bytes_rep : bytes_win;
      job.count   = count;
      job.present = 1'b1;
    end
  end

  assign push     = take && (count != '0 || in_stream.string_end);
  assign job_data = job;

  // configuration and window fill
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      fill               <= '0;
    end else begin
      // a pattern_length write empties the window
      if (cfg.valid && cfg.ready && cfg.index == REG_PATTERN_LENGTH) begin
        fill <= '0;
      end else if (take) begin
        fill <= fill_next;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PATTERN_BYTES: begin
            pattern_bytes <= cfg.data;
          end
          REG_PATTERN_LENGTH: begin
            pattern_length <= cfg.data[LEN_W-1:0];
          end
          REG_REPLACEMENT_BYTES: begin
            replacement_bytes <= cfg.data;
          end
          REG_REPLACEMENT_LENGTH: begin
            replacement_length <= cfg.data[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (take) begin
      window <= window_next;
    end
  end

  `SFR_ASSERT(a_fill_below_len, fill == '0 || fill < plen,
              "window fill reached pattern length")
  `SFR_ASSERT(a_push_has_bytes, push |-> job.count != '0, "emit job with no result")
  `SFR_ASSERT_NEXT(a_len_clears_fill,
                   cfg.valid && cfg.ready && cfg.index == REG_PATTERN_LENGTH,
                   fill == '0, "pattern length write kept window bytes")

endmodule

`default_nettype wire

// File: hw/rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Plays emit jobs out one byte per cycle, as the result side takes them, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_find_and_replace_defines.svh"

module sfr_back import sfr_pkg::*; #(
  parameter  int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter  int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF,
  localparam int JOB_MAX = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
  localparam int CNT_W   = $clog2(JOB_MAX + 1),
  localparam int JOB_W   = JOB_MAX * 8 + CNT_W + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  logic [JOB_W-1:0] head_data,
  output logic             pop,
  sfr_out_if.source        out_stream
);

  typedef struct packed {
    logic [JOB_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic                    present;
    logic                    str_end;
  } job_t;

  job_t             head;
  logic [CNT_W-1:0] pos;
  logic             last;
  logic             adv;
  logic             load;
  logic [7:0]       sel_byte;

  assign head = head_data;
  assign last = (pos == head.count - CNT_W'(1));
  assign adv  = !out_stream.valid || out_stream.ready;
  assign load = head_valid && adv;
  assign pop  = load && last;

  // byte at the current position of the job
  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < JOB_MAX; i++) begin
      if (pos == CNT_W'(i)) begin
        sel_byte = head.bytes[i];
      end
    end
  end

  // position within the job and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      out_stream.valid <= 1'b0;
    end else begin
      if (adv) begin
        out_stream.valid <= head_valid;
      end
      if (load) begin
        pos <= last ? '0 : pos + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_stream.out_byte       <= sel_byte;
      out_stream.out_present    <= head.present;
      out_stream.out_string_end <= head.str_end && last;
      out_stream.run_last       <= last;
    end
  end

  `SFR_ASSERT(a_pos_in_job, head_valid |-> pos < head.count, "position past end of job")
  `SFR_ASSERT(a_end_is_last, out_stream.valid && out_stream.out_string_end |-> out_stream.run_last, "string end not on last result")
  `SFR_ASSERT_NEXT(a_pop_restarts, pop, pos == '0, "position not reset after job")

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream find-and-replace testbench
// Sends byte strings through the block under several pattern and replacement
// settings, from hand-picked corner strings to random strings that mix whole
// and broken pattern occurrences. A built-in rewrite predictor queues the
// expected result bytes; every result request is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  localparam int  SETTLE_CYCLES = 24;        // job queue drain plus pipeline
  localparam int  RANDOM_ITEMS  = 75;
  localparam int  PHASE_ITEMS   = 22;
  localparam time LIMIT_NS      = 3_000_000;

  // one expected result byte
  typedef struct packed {
    logic [7:0] value;
    logic       present;
    logic       str_end;
    logic       last;
  } rewrite_t;

  logic clk = 1'b0;
  logic rst;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();
  sfr_cfg_if cfg_if ();

  stream_find_and_replace u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg        (cfg_if)
  );

  // predictor state: registers and the match window
  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic [63:0] rep_bytes;
  logic [3:0]  rep_len;
  logic [7:0]  win_bytes [8];
  int          win_fill;

  rewrite_t rewrite_q [$];   // expected result bytes, oldest first
  int       errors;
  int       sent_items;      // requests that carry a byte or an end mark
  bit       src_gaps;
  bit       sink_gaps;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int eff_pat_len();
    return (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
  endfunction

  function automatic int eff_rep_len();
    return (rep_len > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : int'(rep_len);
  endfunction

  // predictor: register write
  task automatic apply_reg(input cfg_reg_t idx, input logic [63:0] value);
    case (idx)
      REG_PATTERN_BYTES:      pat_bytes = value;
      REG_PATTERN_LENGTH: begin
        pat_len  = value[3:0];
        win_fill = 0;          // held bytes are dropped
      end
      REG_REPLACEMENT_BYTES:  rep_bytes = value;
      REG_REPLACEMENT_LENGTH: rep_len = value[3:0];
      default: ;
    endcase
  endtask

  // predictor: one input request, queues the result bytes it causes
  task automatic rewrite_item(input logic [7:0] data, input logic present,
                              input logic str_end);
    rewrite_t burst [$];
    int       plen;
    bit       hit;
    plen = eff_pat_len();
    if (present) begin
      if (plen == 0) begin
        burst.push_back('{data, 1'b1, 1'b0, 1'b0});
      end else begin
        if (win_fill >= plen) win_fill = 0;
        win_bytes[win_fill] = data;
        win_fill++;
        if (win_fill == plen) begin
          hit = 1'b1;
          for (int i = 0; i < plen; i++)
            if (win_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            for (int i = 0; i < eff_rep_len(); i++)
              burst.push_back('{rep_bytes[8*i +: 8], 1'b1, 1'b0, 1'b0});
            win_fill = 0;
          end else begin
            // oldest byte can no longer start a match
            burst.push_back('{win_bytes[0], 1'b1, 1'b0, 1'b0});
            for (int i = 1; i < 8; i++) win_bytes[i-1] = win_bytes[i];
            win_fill--;
          end
        end
      end
    end
    if (str_end) begin
      for (int i = 0; i < win_fill; i++)
        burst.push_back('{win_bytes[i], 1'b1, 1'b0, 1'b0});
      win_fill = 0;
      if (burst.size() == 0) burst.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      burst[burst.size()-1].str_end = 1'b1;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) rewrite_q.push_back(burst[i]);
  endtask

  // one input request; valid stays high when the next one follows at once
  task automatic send_byte(input logic [7:0] data, input logic present,
                           input logic str_end);
    int gap;
    gap = src_gaps ? gap_cycles() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= data;
    in_if.byte_present <= present;
    in_if.string_end   <= str_end;
    do @(posedge clk); while (!in_if.ready);
    rewrite_item(data, present, str_end);
    if (present || str_end) sent_items++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(idx, value);
  endtask

  // all four registers, in random order; block must be idle
  task automatic configure(input logic [63:0] pattern, input logic [3:0] plen,
                           input logic [63:0] repl, input logic [3:0] rlen);
    logic [63:0] vals [4];
    int          order [4];
    int          j;
    int          t;
    vals[REG_PATTERN_BYTES]      = pattern;
    vals[REG_PATTERN_LENGTH]     = {60'd0, plen};
    vals[REG_REPLACEMENT_BYTES]  = repl;
    vals[REG_REPLACEMENT_LENGTH] = {60'd0, rlen};
    for (int i = 0; i < 4; i++) order[i] = i;
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 4; i++) write_reg(cfg_reg_t'(order[i]), vals[order[i]]);
    cfg_if.valid <= 1'b0;
  endtask

  // stop sending until every expected byte is out, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (rewrite_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reset settings: empty pattern, bytes go straight through
  task automatic test_pass_through();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);   // bare request without end: ignored
    send_byte(8'h3C, 1'b0, 1'b1);   // bare end mark
    send_byte(8'hA5, 1'b1, 1'b1);   // byte that also ends the string
    drain();
  endtask

  // "ab" -> "XYZ": overlapping start, flush at end, burst ending a string
  task automatic test_basic_replace();
    configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send_byte("a", 1'b1, 1'b0);
    send_byte("a", 1'b1, 1'b0);
    send_byte("b", 1'b1, 1'b0);
    send_byte("a", 1'b1, 1'b1);
    send_byte("a", 1'b1, 1'b0);
    send_byte("b", 1'b1, 1'b1);
    send_byte(8'h77, 1'b0, 1'b1);   // end with an empty window
    drain();
  endtask

  // lengths above the limit saturate; zero-length replacement deletes
  task automatic test_length_limits();
    configure('1, 4'd15, 64'h0123456789ABCDEF, 4'd15);
    repeat (7) send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    drain();
    configure('0, 4'd1, 64'hDEADBEEFCAFEF00D, 4'd0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);   // deleted byte, nothing left: bare end
    drain();
  endtask

  // a pattern_length write drops what the window holds
  task automatic test_window_drop();
    configure(64'h636261, 4'd3, 64'h2A, 4'd1);
    send_byte("a", 1'b1, 1'b0);
    send_byte("b", 1'b1, 1'b0);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    cfg_if.valid <= 1'b0;
    send_byte("c", 1'b1, 1'b1);
    drain();
  endtask

  // random string: whole and broken pattern copies, loose bytes, ignored items
  task automatic send_random_string();
    int len;
    int k;
    int plen;
    int cut;
    plen = eff_pat_len();
    len  = $urandom_range(0, 12);
    k    = 0;
    while (k < len) begin
      if (plen > 0 && $urandom_range(0, 3) == 0) begin
        cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, plen) : plen;
        for (int j = 0; j < cut; j++) send_byte(pat_bytes[8*j +: 8], 1'b1, 1'b0);
        k += cut;
      end else if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
        if (plen > 0 && $urandom_range(0, 1) == 0)
          send_byte(pat_bytes[8*$urandom_range(0, plen-1) +: 8], 1'b1, 1'b0);
        else
          send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        k++;
      end
    end
    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // random phases, each with its own settings and idling mix
  task automatic test_random_strings();
    int          goal;
    int          start;
    int          p;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [63:0] pattern;
    goal = sent_items + RANDOM_ITEMS;
    p = 0;
    while (sent_items < goal) begin
      pattern = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) pattern = {8{pattern[7:0]}};
      case (p)
        0: begin plen = 4'd8; rlen = 4'd8; end
        1: begin plen = 4'd1; rlen = 4'd0; end
        2: begin plen = 4'd0; rlen = 4'($urandom_range(0, 15)); end
        default: begin
          plen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(1, 8));
          rlen = 4'($urandom_range(0, 15));
        end
      endcase
      src_gaps  = (p % 3 != 0);
      sink_gaps = (p % 3 != 1) && (p != 0);
      configure(pattern, plen, {$urandom, $urandom}, rlen);
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS && sent_items < goal)
        send_random_string();
      drain();
      p++;
    end
  endtask

  // result side: random stalls on ready
  initial begin : sink_ready
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && sink_gaps && $urandom_range(0, 2) == 0) hold = gap_cycles();
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // compare each result request with the oldest expected byte
  always @(posedge clk) begin : check_results
    rewrite_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (rewrite_q.size() == 0) begin
        errors++;
        $error("unexpected result: out_byte %02h out_present %0b",
               out_if.out_byte, out_if.out_present);
      end else begin
        want = rewrite_q.pop_front();
        if (out_if.out_byte !== want.value) begin
          errors++;
          $error("out_byte: expected %02h, got %02h", want.value, out_if.out_byte);
        end
        if (out_if.out_present !== want.present) begin
          errors++;
          $error("out_present: expected %0b, got %0b", want.present,
                 out_if.out_present);
        end
        if (out_if.out_string_end !== want.str_end) begin
          errors++;
          $error("out_string_end: expected %0b, got %0b", want.str_end,
                 out_if.out_string_end);
        end
        if (out_if.run_last !== want.last) begin
          errors++;
          $error("run_last: expected %0b, got %0b", want.last, out_if.run_last);
        end
      end
    end
  end

  // main sequence
  initial begin
    rst                <= 1'b1;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= 8'h00;
    in_if.byte_present <= 1'b0;
    in_if.string_end   <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_PATTERN_BYTES;
    cfg_if.data        <= '0;
    pat_bytes  = '0;
    pat_len    = '0;
    rep_bytes  = '0;
    rep_len    = '0;
    win_fill   = 0;
    foreach (win_bytes[i]) win_bytes[i] = 8'h00;
    errors     = 0;
    sent_items = 0;
    src_gaps   = 1'b1;
    sink_gaps  = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_pass_through();
    test_basic_replace();
    test_length_limits();
    test_window_drop();
    test_random_strings();
    drain();

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
